@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the strict priority queue
// Field widths, default sizes, command and status codes, result struct.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int LEVELS_DEF = 8;
	localparam int DEPTH_DEF  = 16;

	localparam int CMD_W    = 1;
	localparam int PRI_W    = 4;
	localparam int NAME_W   = 8;
	localparam int STATUS_W = 3;
	localparam int LEVEL_W  = 4;

	localparam logic [CMD_W-1:0] CMD_ENQUEUE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_DEQUEUE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPRI   = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_EMPTY    = 3'd4
	} spq_status_t;

	typedef struct packed {
		logic                 valid;
		spq_status_t          status;
		logic [LEVEL_W-1:0]   level;
	} spq_result_t;

endpackage

@@ rtl/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl: per-level FIFO bookkeeping and result register
// Holds head pointers and entry counts, picks the level, drives the RAM.
// ----------------------------------------------------------------------------
module spq_ctrl #(
	parameter int LEVELS = spq_pkg::LEVELS_DEF,
	parameter int DEPTH  = spq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [spq_pkg::CMD_W-1:0]          command,
	input  logic [spq_pkg::PRI_W-1:0]          priority_req,
	input  logic [spq_pkg::NAME_W-1:0]         name,
	output logic                               ram_we,
	output logic                               ram_re,
	output logic [$clog2(LEVELS*DEPTH)-1:0]    ram_addr,
	output logic [spq_pkg::NAME_W-1:0]         ram_wdata,
	output spq_pkg::spq_result_t               res
);

	import spq_pkg::*;

	localparam int LVL_W  = $clog2(LEVELS);
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = PTR_W + 1;
	localparam int ADDR_W = $clog2(LEVELS * DEPTH);

	localparam logic [PRI_W:0]   LEVELS_P  = (PRI_W + 1)'(LEVELS);
	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
	localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(DEPTH);

	logic [CNT_W-1:0] count_q [LEVELS];
	logic [PTR_W-1:0] head_q  [LEVELS];

	logic             is_deq;
	logic             pri_ok;
	logic [LVL_W-1:0] enq_lv;
	logic             enq_full;
	logic             any_busy;
	logic [LVL_W-1:0] deq_lv;
	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] deq_head;
	logic [PTR_W-1:0] head_next;
	logic             do_enq;
	logic             do_deq;
	spq_result_t      res_d;
	spq_result_t      res_s1;

	assign is_deq = (command == CMD_DEQUEUE);
	assign pri_ok = (priority_req != '0) && ({1'b0, priority_req} <= LEVELS_P);
	assign enq_lv = LVL_W'(priority_req - PRI_W'(1));
	assign enq_full = (count_q[enq_lv] == DEPTH_C);

	// Lowest-numbered level holding an entry wins.
	always_comb begin
		any_busy = 1'b0;
		deq_lv   = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				any_busy = 1'b1;
				deq_lv   = LVL_W'(i);
			end
		end
	end

	// Tail slot: head plus count, wrapped once since the sum stays below 2*DEPTH.
	assign tail_sum = SUM_W'(head_q[enq_lv]) + SUM_W'(count_q[enq_lv]);
	assign tail     = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);
	assign deq_head = head_q[deq_lv];
	assign head_next = (deq_head == PTR_LAST) ? '0 : deq_head + PTR_W'(1);

	assign do_enq = accept && !is_deq && pri_ok && !enq_full;
	assign do_deq = accept && is_deq && any_busy;

	always_comb begin
		ram_we    = do_enq;
		ram_re    = do_deq;
		ram_wdata = name;
		if (is_deq) begin
			ram_addr = ADDR_W'(deq_lv) * DEPTH_A + ADDR_W'(deq_head);
		end else begin
			ram_addr = ADDR_W'(enq_lv) * DEPTH_A + ADDR_W'(tail);
		end
	end

	always_comb begin
		res_d.valid  = accept;
		res_d.level  = '0;
		if (is_deq) begin
			if (any_busy) begin
				res_d.status = ST_DEQUEUED;
				res_d.level  = LEVEL_W'(deq_lv) + LEVEL_W'(1);
			end else begin
				res_d.status = ST_EMPTY;
			end
		end else if (!pri_ok) begin
			res_d.status = ST_BADPRI;
		end else if (enq_full) begin
			res_d.status = ST_FULL;
		end else begin
			res_d.status = ST_ENQUEUED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else begin
			if (do_enq) begin
				count_q[enq_lv] <= count_q[enq_lv] + CNT_W'(1);
			end
			if (do_deq) begin
				count_q[deq_lv] <= count_q[deq_lv] - CNT_W'(1);
				head_q[deq_lv]  <= head_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else begin
			res_s1 <= res_d;
		end
	end

	assign res = res_s1;

`ifndef NO_ASSERTIONS
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_s1.valid)
		else $error("accepted transaction produced no result");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !res_s1.valid)
		else $error("result without an accepted transaction");

	a_deq_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_deq && any_busy) |=>
			(res_s1.status == ST_DEQUEUED) && (res_s1.level != '0))
		else $error("dequeue from a non-empty queue not reported as dequeued");

	a_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_deq && !any_busy) |=> (res_s1.status == ST_EMPTY))
		else $error("dequeue from an empty queue not reported as empty");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		do_enq |=> (count_q[$past(enq_lv)] <= DEPTH_C))
		else $error("level count exceeded the FIFO depth");
`endif

endmodule

@@ rtl/strict_priority_fifo_queue.sv @@
// ----------------------------------------------------------------------------
// strict_priority_fifo_queue: strict-priority queue of per-level FIFOs
// Latency: a result appears on the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy is never raised, as the level
// bookkeeping and the single slot-RAM access both complete in the cycle of acceptance.
// Reset: arst_n clears every head pointer and entry count; slot RAM is not
// cleared. The receiver cannot stall, so each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module strict_priority_fifo_queue #(
	parameter int LEVELS = spq_pkg::LEVELS_DEF,
	parameter int DEPTH  = spq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [spq_pkg::CMD_W-1:0]     command,
	input  logic [spq_pkg::PRI_W-1:0]     priority_req,
	input  logic [spq_pkg::NAME_W-1:0]    name,
	output logic                          done,
	output logic [spq_pkg::STATUS_W-1:0]  status,
	output logic [spq_pkg::NAME_W-1:0]    name_out,
	output logic [spq_pkg::LEVEL_W-1:0]   level_out
);

	import spq_pkg::*;

	localparam int SLOTS  = LEVELS * DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	logic              accept;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [NAME_W-1:0] ram_wdata;
	logic [NAME_W-1:0] ram_rdata;
	spq_result_t       res;

	// Every transaction finishes its state update in the cycle it is taken,
	// so the block is always ready for the next one.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Head pointers, counts, level selection and the registered result.
	spq_ctrl #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.priority_req (priority_req),
		.name         (name),
		.ram_we       (ram_we),
		.ram_re       (ram_re),
		.ram_addr     (ram_addr),
		.ram_wdata    (ram_wdata),
		.res          (res)
	);

	// Slot storage: level L owns slots L*DEPTH to L*DEPTH+DEPTH-1. A write
	// lands at the edge that accepts an enqueue, so a dequeue in the very
	// next cycle already reads the new name.
	spq_ram #(
		.WIDTH (NAME_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// The RAM read data register lines up with the result register, so the
	// removed name is only gated here; it reads as zero for any other status.
	assign done      = res.valid;
	assign status    = res.status;
	assign level_out = res.level;
	assign name_out  = (res.status == ST_DEQUEUED) ? ram_rdata : '0;

endmodule
